>>> rtl/gnms_pkg.sv
// ----------------------------------------------------------------------------
// gnms_pkg
// Shared types and constants of the gradient non-maximum suppression core.
// ----------------------------------------------------------------------------
package gnms_pkg;

    localparam int GRAD_W            = 16;
    localparam int MAG_W             = GRAD_W + 1;
    localparam int SQ_W              = 2 * GRAD_W + 1;
    localparam int FRAC_BITS         = 4;
    localparam int EDGE_W            = 8;

    localparam int WIDTH_W           = 11;
    localparam int HEIGHT_W          = 13;
    localparam int ROW_W             = 12;
    localparam int CFG_DATA_W        = 13;
    localparam int CFG_INDEX_W       = 2;

    localparam int DEFAULT_MAX_WIDTH = 1024;
    localparam int RESET_WIDTH       = 640;
    localparam int RESET_HEIGHT      = 480;
    localparam int DIM_MIN           = 3;
    localparam int HEIGHT_MAX        = 4096;

    localparam int QUEUE_DEPTH       = 32;
    localparam int OUT_DEPTH         = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic signed [GRAD_W-1:0] grad_x;
        logic signed [GRAD_W-1:0] grad_y;
    } in_item_t;

    typedef struct packed {
        logic [EDGE_W-1:0] edge_value;
        logic              frame_first;
    } out_item_t;

    // front to back: magnitude plus the raw gradient
    typedef struct packed {
        logic [MAG_W-1:0]         mag;
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
    } mag_item_t;

    localparam int MAG_ITEM_W = $bits(mag_item_t);
    localparam int OUT_ITEM_W = $bits(out_item_t);

endpackage

>>> rtl/gnms_fifo.sv
// ----------------------------------------------------------------------------
// gnms_fifo
// Queue with a memory array and a registered output word; used as both the request and the result queue.
// ----------------------------------------------------------------------------
module gnms_fifo #(
    parameter int WIDTH = gnms_pkg::MAG_ITEM_W,
    parameter int DEPTH = gnms_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic             dout_valid,
    output logic [WIDTH-1:0] dout
);
    import gnms_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      cnt_reg;
    logic [AW:0]      cnt_next;
    logic [WIDTH-1:0] dout_reg;
    logic             out_valid_reg;
    logic             load;

    assign load       = (cnt_reg != '0) && (!out_valid_reg || pop);
    assign dout_valid = out_valid_reg;
    assign dout       = dout_reg;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !load) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!push && load) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= din;
        end
        if (load) begin
            dout_reg <= mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (load) begin
                rd_ptr_reg    <= rd_ptr_reg + 1'b1;
                out_valid_reg <= 1'b1;
            end else if (pop) begin
                out_valid_reg <= 1'b0;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> rtl/gnms_front.sv
// ----------------------------------------------------------------------------
// gnms_front
// Input side: takes gradient requests, squares them and runs a pipelined
// square root, one result bit per stage, into the request queue.
// ----------------------------------------------------------------------------
module gnms_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  gnms_pkg::in_item_t  s_data,
    output logic                q_push,
    output gnms_pkg::mag_item_t q_push_item,
    input  logic                q_pop
);
    import gnms_pkg::*;

    localparam int CRED_W = $clog2(QUEUE_DEPTH) + 1;
    localparam int RW     = SQ_W + 1;

    logic [CRED_W-1:0]        cred_reg;
    logic                     accept;
    logic [MAG_W:0]           valid_reg;
    logic [RW-1:0]            rem_reg [MAG_W+1];
    logic [RW-1:0]            res_reg [MAG_W+1];
    logic signed [GRAD_W-1:0] gx_reg  [MAG_W+1];
    logic signed [GRAD_W-1:0] gy_reg  [MAG_W+1];
    logic signed [2*GRAD_W-1:0] sq_x;
    logic signed [2*GRAD_W-1:0] sq_y;

    // credits cover everything in the pipe and in the queue
    assign s_ready = cred_reg < CRED_W'(QUEUE_DEPTH);
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cred_reg  <= '0;
            valid_reg <= '0;
        end else begin
            valid_reg <= {valid_reg[MAG_W-1:0], accept};
            if (accept && !q_pop) begin
                cred_reg <= cred_reg + 1'b1;
            end else if (!accept && q_pop) begin
                cred_reg <= cred_reg - 1'b1;
            end
        end
    end

    assign sq_x = s_data.grad_x * s_data.grad_x;
    assign sq_y = s_data.grad_y * s_data.grad_y;

    always_ff @(posedge aclk) begin
        rem_reg[0] <= RW'(unsigned'(sq_x)) + RW'(unsigned'(sq_y));
        res_reg[0] <= '0;
        gx_reg[0]  <= s_data.grad_x;
        gy_reg[0]  <= s_data.grad_y;
    end

    for (genvar i = 0; i < MAG_W; i++) begin : g_sqrt
        localparam logic [RW-1:0] BIT = RW'(1) << (2 * (MAG_W - 1 - i));
        logic [RW-1:0] trial;
        logic          take;

        assign trial = res_reg[i] + BIT;
        assign take  = rem_reg[i] >= trial;

        always_ff @(posedge aclk) begin
            rem_reg[i+1] <= take ? (rem_reg[i] - trial) : rem_reg[i];
            res_reg[i+1] <= take ? ((res_reg[i] >> 1) + BIT) : (res_reg[i] >> 1);
            gx_reg[i+1]  <= gx_reg[i];
            gy_reg[i+1]  <= gy_reg[i];
        end
    end

    assign q_push          = valid_reg[MAG_W];
    assign q_push_item.mag = res_reg[MAG_W][MAG_W-1:0];
    assign q_push_item.gx  = gx_reg[MAG_W];
    assign q_push_item.gy  = gy_reg[MAG_W];

endmodule

>>> rtl/gnms_back.sv
// ----------------------------------------------------------------------------
// gnms_back
// Output side: raster position, line store, 3x3 window and the interpolated
// suppression test, four stages deep, into the result queue.
// ----------------------------------------------------------------------------
module gnms_back #(
    parameter int MAX_WIDTH = gnms_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [gnms_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [gnms_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  logic                                q_valid,
    input  gnms_pkg::mag_item_t                 q_item,
    output logic                                q_pop,
    output logic                                push,
    output gnms_pkg::out_item_t                 push_item,
    input  logic                                out_pop
);
    import gnms_pkg::*;

    localparam int COL_W  = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int EW     = COL_W + 1;
    localparam int CRED_W = $clog2(OUT_DEPTH) + 1;
    localparam int PW     = MAG_W + GRAD_W + 3;

    typedef struct packed {
        logic [MAG_W-1:0]         l1;
        logic [MAG_W-1:0]         l0;
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
    } line_entry_t;

    // configuration and raster position
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [EW-1:0]       eff_w;
    logic [HEIGHT_W-1:0] eff_h;
    logic                restart;
    logic [COL_W-1:0]    col_reg;
    logic [COL_W-1:0]    col_next;
    logic [ROW_W-1:0]    row_reg;
    logic [ROW_W-1:0]    row_next;
    logic [CRED_W-1:0]   cred_reg;

    // line store
    line_entry_t         line_mem [MAX_WIDTH];
    line_entry_t         rdata_reg;

    // stage 1
    logic                s1_valid_reg;
    mag_item_t           s1_item_reg;
    logic [COL_W-1:0]    s1_col_reg;
    logic                s1_edge_ok_reg;
    logic                s1_first_reg;
    logic [MAG_W-1:0]    win_reg  [3][3];
    logic [MAG_W-1:0]    win_next [3][3];
    logic signed [GRAD_W-1:0] ch_gx_reg;
    logic signed [GRAD_W-1:0] ch_gy_reg;

    logic [GRAD_W-1:0]   ax;
    logic [GRAD_W-1:0]   ay;
    logic                nonneg;
    logic [MAG_W-1:0]    sel_pa, sel_pb, sel_qa, sel_qb;
    logic [GRAD_W-1:0]   sel_num, sel_den;

    // stage 2
    logic                s2_valid_reg;
    logic [MAG_W-1:0]    s2_m_reg;
    logic [MAG_W-1:0]    s2_pa_reg;
    logic [MAG_W-1:0]    s2_qa_reg;
    logic signed [MAG_W:0] s2_dp_reg;
    logic signed [MAG_W:0] s2_dq_reg;
    logic [GRAD_W-1:0]   s2_num_reg;
    logic [GRAD_W-1:0]   s2_den_reg;
    logic                s2_strict_p_reg;
    logic                s2_zero_reg;
    logic                s2_edge_ok_reg;
    logic                s2_first_reg;

    // stage 3
    logic                        s3_valid_reg;
    logic [MAG_W+GRAD_W-1:0]     s3_lhs_reg;
    logic [MAG_W+GRAD_W-1:0]     s3_ap_reg;
    logic [MAG_W+GRAD_W-1:0]     s3_aq_reg;
    logic signed [MAG_W+GRAD_W+1:0] s3_pn_reg;
    logic signed [MAG_W+GRAD_W+1:0] s3_qn_reg;
    logic [MAG_W-1:0]            s3_m_reg;
    logic                        s3_strict_p_reg;
    logic                        s3_zero_reg;
    logic                        s3_edge_ok_reg;
    logic                        s3_first_reg;

    // stage 4
    logic signed [PW-1:0] lhs_s, rhs_p, rhs_q;
    logic                 gt_p, ge_p, gt_q, ge_q, keep;
    logic [EDGE_W-1:0]    sat_val;
    logic                 s4_valid_reg;
    out_item_t            s4_item_reg;

    // ---------------------------------------------------------------- config
    assign restart = cfg_wr_en &&
                     ((cfg_index == CFG_FRAME_WIDTH) || (cfg_index == CFG_FRAME_HEIGHT));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_W'(RESET_WIDTH);
            height_reg <= HEIGHT_W'(RESET_HEIGHT);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  width_reg  <= cfg_wr_data[WIDTH_W-1:0];
                CFG_FRAME_HEIGHT: height_reg <= cfg_wr_data[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (32'(width_reg) < 32'(DIM_MIN)) begin
            eff_w = EW'(DIM_MIN);
        end else if (32'(width_reg) > 32'(MAX_WIDTH)) begin
            eff_w = EW'(MAX_WIDTH);
        end else begin
            eff_w = EW'(width_reg);
        end
        if (32'(height_reg) < 32'(DIM_MIN)) begin
            eff_h = HEIGHT_W'(DIM_MIN);
        end else if (32'(height_reg) > 32'(HEIGHT_MAX)) begin
            eff_h = HEIGHT_W'(HEIGHT_MAX);
        end else begin
            eff_h = height_reg;
        end
    end

    // -------------------------------------------------------------- position
    assign q_pop = q_valid && (cred_reg < CRED_W'(OUT_DEPTH));

    always_comb begin
        col_next = col_reg + 1'b1;
        row_next = row_reg;
        if (({1'b0, col_reg} + 1'b1) >= eff_w) begin
            col_next = '0;
            if (({1'b0, row_reg} + 1'b1) >= eff_h) begin
                row_next = '0;
            end else begin
                row_next = row_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            cred_reg <= '0;
        end else begin
            if (restart) begin
                col_reg <= '0;
                row_reg <= '0;
            end else if (q_pop) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (q_pop && !out_pop) begin
                cred_reg <= cred_reg + 1'b1;
            end else if (!q_pop && out_pop) begin
                cred_reg <= cred_reg - 1'b1;
            end
        end
    end

    // ------------------------------------------------------------ line store
    // read at pop, write back in the next cycle once the old row is known
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            rdata_reg <= line_mem[col_reg];
        end
        if (s1_valid_reg) begin
            line_mem[s1_col_reg] <= '{l1: rdata_reg.l0, l0: s1_item_reg.mag,
                                      gx: s1_item_reg.gx, gy: s1_item_reg.gy};
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            s1_item_reg    <= q_item;
            s1_col_reg     <= col_reg;
            s1_edge_ok_reg <= (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));
            s1_first_reg   <= (row_reg == ROW_W'(1)) && (col_reg == COL_W'(1));
        end
    end

    // -------------------------------------------------------- window, select
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            win_next[k][0] = win_reg[k][1];
            win_next[k][1] = win_reg[k][2];
        end
        win_next[0][2] = rdata_reg.l1;
        win_next[1][2] = rdata_reg.l0;
        win_next[2][2] = s1_item_reg.mag;
    end

    assign ax     = ch_gx_reg[GRAD_W-1] ? GRAD_W'(-ch_gx_reg) : GRAD_W'(ch_gx_reg);
    assign ay     = ch_gy_reg[GRAD_W-1] ? GRAD_W'(-ch_gy_reg) : GRAD_W'(ch_gy_reg);
    assign nonneg = (ch_gx_reg == '0) || (ch_gx_reg[GRAD_W-1] == ch_gy_reg[GRAD_W-1]);

    always_comb begin
        priority if (ch_gy_reg == '0) begin
            // horizontal: strict toward the side the gradient points at
            sel_num = '0;
            sel_den = GRAD_W'(1);
            if (ch_gx_reg[GRAD_W-1]) begin
                sel_pa = win_next[1][0];
                sel_qa = win_next[1][2];
            end else begin
                sel_pa = win_next[1][2];
                sel_qa = win_next[1][0];
            end
            sel_pb = sel_pa;
            sel_qb = sel_qa;
        end else if (nonneg && (ax >= ay)) begin
            sel_pa = win_next[1][2]; sel_pb = win_next[2][2];
            sel_qa = win_next[1][0]; sel_qb = win_next[0][0];
            sel_num = ay; sel_den = ax;
        end else if (nonneg) begin
            sel_pa = win_next[2][1]; sel_pb = win_next[2][2];
            sel_qa = win_next[0][1]; sel_qb = win_next[0][0];
            sel_num = ax; sel_den = ay;
        end else if (ax <= ay) begin
            sel_pa = win_next[2][1]; sel_pb = win_next[2][0];
            sel_qa = win_next[0][1]; sel_qb = win_next[0][2];
            sel_num = ax; sel_den = ay;
        end else begin
            sel_pa = win_next[1][0]; sel_pb = win_next[2][0];
            sel_qa = win_next[1][2]; sel_qb = win_next[0][2];
            sel_num = ay; sel_den = ax;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            win_reg         <= win_next;
            ch_gx_reg       <= rdata_reg.gx;
            ch_gy_reg       <= rdata_reg.gy;
            s2_m_reg        <= win_next[1][1];
            s2_pa_reg       <= sel_pa;
            s2_qa_reg       <= sel_qa;
            s2_dp_reg       <= $signed({1'b0, sel_pb}) - $signed({1'b0, sel_pa});
            s2_dq_reg       <= $signed({1'b0, sel_qb}) - $signed({1'b0, sel_qa});
            s2_num_reg      <= sel_num;
            s2_den_reg      <= sel_den;
            s2_strict_p_reg <= !ch_gy_reg[GRAD_W-1];
            s2_zero_reg     <= (ch_gx_reg == '0) && (ch_gy_reg == '0);
            s2_edge_ok_reg  <= s1_edge_ok_reg;
            s2_first_reg    <= s1_first_reg;
        end
    end

    // ------------------------------------------------------------- products
    always_ff @(posedge aclk) begin
        s3_lhs_reg      <= s2_m_reg * s2_den_reg;
        s3_ap_reg       <= s2_pa_reg * s2_den_reg;
        s3_aq_reg       <= s2_qa_reg * s2_den_reg;
        s3_pn_reg       <= s2_dp_reg * $signed({1'b0, s2_num_reg});
        s3_qn_reg       <= s2_dq_reg * $signed({1'b0, s2_num_reg});
        s3_m_reg        <= s2_m_reg;
        s3_strict_p_reg <= s2_strict_p_reg;
        s3_zero_reg     <= s2_zero_reg;
        s3_edge_ok_reg  <= s2_edge_ok_reg;
        s3_first_reg    <= s2_first_reg;
    end

    // ------------------------------------------------------------ decision
    assign lhs_s = PW'($signed({1'b0, s3_lhs_reg}));
    assign rhs_p = PW'($signed({1'b0, s3_ap_reg})) + PW'(s3_pn_reg);
    assign rhs_q = PW'($signed({1'b0, s3_aq_reg})) + PW'(s3_qn_reg);
    assign gt_p  = lhs_s > rhs_p;
    assign ge_p  = lhs_s >= rhs_p;
    assign gt_q  = lhs_s > rhs_q;
    assign ge_q  = lhs_s >= rhs_q;
    assign keep  = s3_edge_ok_reg && !s3_zero_reg &&
                   (s3_strict_p_reg ? (gt_p && ge_q) : (ge_p && gt_q));
    assign sat_val = (s3_m_reg[MAG_W-1:FRAC_BITS+EDGE_W] != '0) ? '1
                   : s3_m_reg[FRAC_BITS+EDGE_W-1:FRAC_BITS];

    always_ff @(posedge aclk) begin
        s4_item_reg.edge_value  <= keep ? sat_val : '0;
        s4_item_reg.frame_first <= s3_first_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= q_pop;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    assign push      = s4_valid_reg;
    assign push_item = s4_item_reg;

endmodule

>>> rtl/gradient_non_maximum_suppression_core.sv
// ----------------------------------------------------------------------------
// gradient_non_maximum_suppression_core
// Streaming non-maximum suppression of a gradient image with interpolation.
// ----------------------------------------------------------------------------
// Takes one (grad_x, grad_y) pixel per clock while s_ready is high, in raster
// order, and returns one result per pixel; each result belongs to the pixel
// frame_width+1 positions earlier, and border pixels (and the first
// frame_width+1 results after reset or a register write) give 0. Sustained
// rate is one pixel per clock while m_ready stays high, set by the simple
// dual-port line store, read at one column and written back at another on
// every clock. An accepted pixel passes through the squaring and
// bit-per-stage square root pipeline, the request queue, the window and
// compare stages and the result queue to its result word.
// The line store needs no clearing after reset.
// Write frame_width and frame_height only while the block is idle; a write
// restarts the frame at row 0, column 0.
// ----------------------------------------------------------------------------
module gradient_non_maximum_suppression_core #(
    parameter int MAX_WIDTH = gnms_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [gnms_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gnms_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  gnms_pkg::in_item_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output gnms_pkg::out_item_t              m_data
);
    import gnms_pkg::*;

    logic                  q_push;
    mag_item_t             q_push_item;
    logic                  q_pop;
    logic                  q_valid;
    logic [MAG_ITEM_W-1:0] q_dout;
    logic                  r_push;
    out_item_t             r_push_item;
    logic                  m_pop;
    logic [OUT_ITEM_W-1:0] r_dout;

    assign m_pop  = m_valid && m_ready;
    assign m_data = out_item_t'(r_dout);

    gnms_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .q_push      (q_push),
        .q_push_item (q_push_item),
        .q_pop       (q_pop)
    );

    gnms_fifo #(
        .WIDTH (MAG_ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_req_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .din        (q_push_item),
        .pop        (q_pop),
        .dout_valid (q_valid),
        .dout       (q_dout)
    );

    gnms_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_item      (mag_item_t'(q_dout)),
        .q_pop       (q_pop),
        .push        (r_push),
        .push_item   (r_push_item),
        .out_pop     (m_pop)
    );

    gnms_fifo #(
        .WIDTH (OUT_ITEM_W),
        .DEPTH (OUT_DEPTH)
    ) u_res_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (r_push),
        .din        (r_push_item),
        .pop        (m_pop),
        .dout_valid (m_valid),
        .dout       (r_dout)
    );

endmodule
